// ----- rtl/sfba_pkg.sv -----
// Shared types and constants for the segregated-fit block allocator.
// No dependencies; every other file except sfba_ram refers to this package by scoped names.
package sfba_pkg;

  localparam int MAX_BLOCKS_DEF  = 256;
  localparam int ADDR_W          = 32;
  localparam int SIZE_W          = 19;
  localparam int BYTES_W         = 21;
  localparam int CLS_W           = 5;
  localparam int MAX_CLASSES     = 16;
  localparam int MIN_BLOCK_SHIFT = 3;
  localparam int BLK_OUT_W       = 9;
  localparam int BLK_OUT_MAX     = 511;
  localparam int UBYTES_W        = 25;
  localparam int CNT_W           = 32;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_CLASS = 2'd2;

  localparam logic [ADDR_W-1:0]  HEAP_BASE_RST = 32'd0;
  localparam logic [CLS_W-1:0]   NUM_CLS_RST   = 5'd8;
  localparam logic [BYTES_W-1:0] BPC_RST       = 21'd4096;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADFREE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_CLS,
    S_INIT_RUN,
    S_SCAN,
    S_EVAL,
    S_SPLIT,
    S_TAKE,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              taken;
  } entry_t;

  typedef struct packed {
    logic    accept;
    logic    start_init;
    logic    cls_load;
    logic    cls_next;
    logic    place;
    logic    scan_start;
    logic    scan_run;
    logic    wr_split;
    logic    wr_take;
    logic    wr_free;
    logic    finish;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    req_type_t in_type;
    req_type_t req_type;
    logic      cls_end;
    logic      rem_zero;
    logic      full;
    logic      scan_done;
    logic      found;
    logic      need_split;
    logic      req_zero;
    logic      addr_zero;
    logic      out_free;
  } stat_t;

endpackage

// ----- rtl/sfba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sfba_ctrl.sv -----
// Sequencer for the allocator: init build, table scan and write-back steps.
// Depends on sfba_pkg; drives sfba_dp through cmd_t and watches stat_t.
module sfba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sfba_pkg::stat_t stat,
  output sfba_pkg::cmd_t  cmd
);

  sfba_pkg::state_t  state_r, state_nxt;
  sfba_pkg::status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sfba_pkg::S_IDLE;
      status_r <= sfba_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.res_status = status_r;
    in_ready       = 1'b0;
    unique case (state_r)
      sfba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (stat.in_type)
            sfba_pkg::REQ_INIT: begin
              cmd.start_init = 1'b1;
              state_nxt      = sfba_pkg::S_INIT_CLS;
            end
            sfba_pkg::REQ_ALLOC, sfba_pkg::REQ_FREE: begin
              cmd.scan_start = 1'b1;
              state_nxt      = sfba_pkg::S_SCAN;
            end
            default: begin
              status_nxt = sfba_pkg::ST_OK;
              state_nxt  = sfba_pkg::S_DONE;
            end
          endcase
        end
      end
      sfba_pkg::S_INIT_CLS: begin
        if (stat.cls_end) begin
          status_nxt = sfba_pkg::ST_OK;
          state_nxt  = sfba_pkg::S_DONE;
        end else begin
          cmd.cls_load = 1'b1;
          state_nxt    = sfba_pkg::S_INIT_RUN;
        end
      end
      sfba_pkg::S_INIT_RUN: begin
        if (stat.rem_zero) begin
          cmd.cls_next = 1'b1;
          state_nxt    = sfba_pkg::S_INIT_CLS;
        end else if (stat.full) begin
          status_nxt = sfba_pkg::ST_FULL;
          state_nxt  = sfba_pkg::S_DONE;
        end else begin
          cmd.place = 1'b1;
        end
      end
      sfba_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = sfba_pkg::S_EVAL;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      sfba_pkg::S_EVAL: begin
        if (stat.req_type == sfba_pkg::REQ_ALLOC) begin
          if (stat.req_zero || !stat.found) begin
            status_nxt = sfba_pkg::ST_NOMEM;
            state_nxt  = sfba_pkg::S_DONE;
          end else if (stat.need_split && stat.full) begin
            status_nxt = sfba_pkg::ST_FULL;
            state_nxt  = sfba_pkg::S_DONE;
          end else if (stat.need_split) begin
            state_nxt = sfba_pkg::S_SPLIT;
          end else begin
            state_nxt = sfba_pkg::S_TAKE;
          end
        end else begin
          if (stat.addr_zero || !stat.found) begin
            status_nxt = sfba_pkg::ST_BADFREE;
            state_nxt  = sfba_pkg::S_DONE;
          end else begin
            state_nxt = sfba_pkg::S_FREE;
          end
        end
      end
      sfba_pkg::S_SPLIT: begin
        cmd.wr_split = 1'b1;
        state_nxt    = sfba_pkg::S_TAKE;
      end
      sfba_pkg::S_TAKE: begin
        cmd.wr_take = 1'b1;
        status_nxt  = sfba_pkg::ST_OK;
        state_nxt   = sfba_pkg::S_DONE;
      end
      sfba_pkg::S_FREE: begin
        cmd.wr_free = 1'b1;
        status_nxt  = sfba_pkg::ST_OK;
        state_nxt   = sfba_pkg::S_DONE;
      end
      sfba_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = sfba_pkg::S_IDLE;
        end
      end
      default: state_nxt = sfba_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/sfba_dp.sv -----
// Datapath: config registers, block table RAM, scan/compare, counters, output register.
// Depends on sfba_pkg and sfba_ram; sequenced by sfba_ctrl.
module sfba_dp #(
  parameter int MAX_BLOCKS = sfba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [sfba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata,
  input  logic [1:0]                          in_req_type,
  input  logic [sfba_pkg::BYTES_W-1:0]        in_req_bytes,
  input  logic [sfba_pkg::ADDR_W-1:0]         in_req_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [sfba_pkg::ADDR_W-1:0]         out_grant_address,
  output logic [sfba_pkg::BLK_OUT_W-1:0]      out_free_blocks,
  output logic [sfba_pkg::BLK_OUT_W-1:0]      out_used_blocks,
  output logic [sfba_pkg::UBYTES_W-1:0]       out_used_bytes,
  output logic [sfba_pkg::CNT_W-1:0]          out_alloc_calls,
  output logic [sfba_pkg::CNT_W-1:0]          out_free_calls,
  output logic [sfba_pkg::CNT_W-1:0]          out_split_calls,
  input  sfba_pkg::cmd_t                      cmd,
  output sfba_pkg::stat_t                     stat
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = $bits(sfba_pkg::entry_t);

  // configuration
  logic [sfba_pkg::ADDR_W-1:0]  heap_base_r;
  logic [sfba_pkg::CLS_W-1:0]   num_cls_r;
  logic [sfba_pkg::BYTES_W-1:0] bpc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= sfba_pkg::HEAP_BASE_RST;
      num_cls_r   <= sfba_pkg::NUM_CLS_RST;
      bpc_r       <= sfba_pkg::BPC_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfba_pkg::CFG_HEAP_BASE:       heap_base_r <= cfg_wdata;
        sfba_pkg::CFG_NUM_CLASSES:     num_cls_r   <= cfg_wdata[sfba_pkg::CLS_W-1:0];
        sfba_pkg::CFG_BYTES_PER_CLASS: bpc_r       <= cfg_wdata[sfba_pkg::BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  sfba_pkg::req_type_t          req_type_r;
  logic [sfba_pkg::BYTES_W-1:0] req_bytes_r;
  logic [sfba_pkg::ADDR_W-1:0]  req_addr_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type_r  <= sfba_pkg::req_type_t'(in_req_type);
      req_bytes_r <= in_req_bytes;
      req_addr_r  <= in_req_address;
    end
  end

  // table occupancy: valid entries always form the prefix [0, fill)
  logic [CW-1:0] fill_r;
  logic          full;
  assign full = (fill_r == CW'(MAX_BLOCKS));

  // init build state
  logic [sfba_pkg::CLS_W-1:0]  cls_r;
  logic [sfba_pkg::SIZE_W-1:0] rem_r;
  logic [sfba_pkg::SIZE_W-1:0] sz_r;
  logic [sfba_pkg::ADDR_W-1:0] naddr_r;
  logic [sfba_pkg::CLS_W-1:0]  nc;
  assign nc = (num_cls_r > sfba_pkg::CLS_W'(sfba_pkg::MAX_CLASSES))
            ? sfba_pkg::CLS_W'(sfba_pkg::MAX_CLASSES) : num_cls_r;

  // scan state
  logic [CW-1:0]               k_r;
  logic [IW-1:0]               kd_r;
  logic                        pend_r;
  logic                        found_r;
  logic [IW-1:0]               bidx_r;
  logic [sfba_pkg::ADDR_W-1:0] baddr_r;
  logic [sfba_pkg::SIZE_W-1:0] bsize_r;
  logic                        split_r;

  // RAM
  sfba_pkg::entry_t rd_ent, wr_ent;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [EW-1:0]    rdata;

  sfba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_ent),
    .raddr (k_r[IW-1:0]),
    .rdata (rdata)
  );
  assign rd_ent = sfba_pkg::entry_t'(rdata);

  always_comb begin
    we     = 1'b0;
    waddr  = fill_r[IW-1:0];
    wr_ent = '0;
    if (cmd.place) begin
      we     = 1'b1;
      wr_ent = '{addr: naddr_r, size: sz_r, taken: 1'b0};
    end else if (cmd.wr_split) begin
      we     = 1'b1;
      wr_ent = '{addr: baddr_r + sfba_pkg::ADDR_W'(req_bytes_r),
                 size: bsize_r - req_bytes_r[sfba_pkg::SIZE_W-1:0], taken: 1'b0};
    end else if (cmd.wr_take) begin
      we     = 1'b1;
      waddr  = bidx_r;
      wr_ent = '{addr: baddr_r, size: req_bytes_r[sfba_pkg::SIZE_W-1:0], taken: 1'b1};
    end else if (cmd.wr_free) begin
      we     = 1'b1;
      waddr  = bidx_r;
      wr_ent = '{addr: baddr_r, size: bsize_r, taken: 1'b0};
    end
  end

  // candidate test on the entry read last cycle
  logic hit;
  always_comb begin
    if (req_type_r == sfba_pkg::REQ_ALLOC) begin
      hit = !rd_ent.taken
          && (sfba_pkg::BYTES_W'(rd_ent.size) >= req_bytes_r)
          && (!found_r || (rd_ent.size < bsize_r)
              || ((rd_ent.size == bsize_r) && (rd_ent.addr < baddr_r)));
    end else begin
      hit = rd_ent.taken && (rd_ent.addr == req_addr_r) && !found_r;
    end
  end

  // table, scan and build registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      split_r <= 1'b0;
      k_r     <= '0;
      cls_r   <= '0;
    end else begin
      if (cmd.start_init) begin
        fill_r  <= '0;
        cls_r   <= '0;
        naddr_r <= heap_base_r;
      end
      if (cmd.cls_load) begin
        rem_r <= sfba_pkg::SIZE_W'(bpc_r >> (sfba_pkg::MIN_BLOCK_SHIFT + 32'(cls_r)));
        sz_r  <= sfba_pkg::SIZE_W'(1) << (sfba_pkg::MIN_BLOCK_SHIFT + 32'(cls_r));
      end
      if (cmd.cls_next) begin
        cls_r <= cls_r + 1'b1;
      end
      if (cmd.place) begin
        fill_r  <= fill_r + 1'b1;
        rem_r   <= rem_r - 1'b1;
        naddr_r <= naddr_r + sfba_pkg::ADDR_W'(sz_r);
      end
      if (cmd.scan_start) begin
        k_r     <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
        split_r <= 1'b0;
      end
      if (cmd.scan_run) begin
        if (pend_r && hit) begin
          found_r <= 1'b1;
          bidx_r  <= kd_r;
          baddr_r <= rd_ent.addr;
          bsize_r <= rd_ent.size;
        end
        if (k_r < fill_r) begin
          pend_r <= 1'b1;
          kd_r   <= k_r[IW-1:0];
          k_r    <= k_r + 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (cmd.wr_split) begin
        fill_r  <= fill_r + 1'b1;
        split_r <= 1'b1;
      end
    end
  end

  // running counts and counters
  logic [CW-1:0]                 nfree_r, nused_r;
  logic [sfba_pkg::UBYTES_W-1:0] ubytes_r;
  logic [sfba_pkg::CNT_W-1:0]    alloc_r, free_r, splitc_r;
  logic [sfba_pkg::ADDR_W-1:0]   grant_r;

  function automatic logic [sfba_pkg::CNT_W-1:0] sat_inc(
    input logic [sfba_pkg::CNT_W-1:0] v
  );
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfree_r  <= '0;
      nused_r  <= '0;
      ubytes_r <= '0;
      alloc_r  <= '0;
      free_r   <= '0;
      splitc_r <= '0;
      grant_r  <= '0;
    end else begin
      if (cmd.accept) begin
        grant_r <= '0;
      end
      if (cmd.start_init) begin
        nfree_r  <= '0;
        nused_r  <= '0;
        ubytes_r <= '0;
        alloc_r  <= '0;
        free_r   <= '0;
        splitc_r <= '0;
      end
      if (cmd.place) begin
        nfree_r <= nfree_r + 1'b1;
      end
      if (cmd.wr_take) begin
        // a split adds one free block and takes one: net zero
        if (!split_r) begin
          nfree_r <= nfree_r - 1'b1;
        end else begin
          splitc_r <= sat_inc(splitc_r);
        end
        nused_r  <= nused_r + 1'b1;
        ubytes_r <= ubytes_r + sfba_pkg::UBYTES_W'(req_bytes_r);
        alloc_r  <= sat_inc(alloc_r);
        grant_r  <= baddr_r;
      end
      if (cmd.wr_free) begin
        nfree_r  <= nfree_r + 1'b1;
        nused_r  <= nused_r - 1'b1;
        ubytes_r <= ubytes_r - sfba_pkg::UBYTES_W'(bsize_r);
        free_r   <= sat_inc(free_r);
      end
    end
  end

  // output register
  logic [31:0] nfree_x, nused_x;
  assign nfree_x = 32'(nfree_r);
  assign nused_x = 32'(nused_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status        <= cmd.res_status;
      out_grant_address <= grant_r;
      out_free_blocks   <= (nfree_x > 32'(sfba_pkg::BLK_OUT_MAX))
                         ? sfba_pkg::BLK_OUT_W'(sfba_pkg::BLK_OUT_MAX)
                         : nfree_x[sfba_pkg::BLK_OUT_W-1:0];
      out_used_blocks   <= (nused_x > 32'(sfba_pkg::BLK_OUT_MAX))
                         ? sfba_pkg::BLK_OUT_W'(sfba_pkg::BLK_OUT_MAX)
                         : nused_x[sfba_pkg::BLK_OUT_W-1:0];
      out_used_bytes    <= ubytes_r;
      out_alloc_calls   <= alloc_r;
      out_free_calls    <= free_r;
      out_split_calls   <= splitc_r;
    end
  end

  // status to controller
  always_comb begin
    stat            = '0;
    stat.in_type    = sfba_pkg::req_type_t'(in_req_type);
    stat.req_type   = req_type_r;
    stat.cls_end    = (cls_r == nc);
    stat.rem_zero   = (rem_r == '0);
    stat.full       = full;
    stat.scan_done  = !pend_r && (k_r >= fill_r);
    stat.found      = found_r;
    stat.need_split = (sfba_pkg::BYTES_W'(bsize_r) > req_bytes_r);
    stat.req_zero   = (req_bytes_r == '0);
    stat.addr_zero  = (req_addr_r == '0);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

// ----- rtl/segregated_fit_block_allocator.sv -----
// Top level of the segregated-fit block allocator.
// Depends on sfba_pkg, sfba_ctrl, sfba_dp (which holds sfba_ram).
//
// Usage:
//   cfg_*  : register writes (0 heap base, 1 class count, 2 bytes per class),
//            taken every cycle; write only while no transaction is in flight.
//   in_*   : one request per transaction: init heap, allocate or free.
//   out_*  : exactly one result transaction per request, with status, grant
//            address, block/byte counts and the saturating call counters.
// Init places the blocks class by class, one table entry written per cycle
// within a class. Allocate and free scan the table through the RAM read port,
// one entry per cycle, up to MAX_BLOCKS entries; a split adds a write step
// (S_SPLIT) before the take. Unknown requests go straight to the result. One
// request is in work at a time; the next is accepted as soon as the result is
// in the output register. Reset clears the table (empty), the counters and the
// config registers to their defaults; no clearing pass is needed. If the
// receiver stalls, the result is held in the output register, and a finished
// next request waits in its last step until the register is taken.
module segregated_fit_block_allocator #(
  parameter int MAX_BLOCKS = sfba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [sfba_pkg::BYTES_W-1:0]   in_req_bytes,
  input  logic [sfba_pkg::ADDR_W-1:0]    in_req_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [sfba_pkg::ADDR_W-1:0]    out_grant_address,
  output logic [sfba_pkg::BLK_OUT_W-1:0] out_free_blocks,
  output logic [sfba_pkg::BLK_OUT_W-1:0] out_used_blocks,
  output logic [sfba_pkg::UBYTES_W-1:0]  out_used_bytes,
  output logic [sfba_pkg::CNT_W-1:0]     out_alloc_calls,
  output logic [sfba_pkg::CNT_W-1:0]     out_free_calls,
  output logic [sfba_pkg::CNT_W-1:0]     out_split_calls
);

  sfba_pkg::cmd_t  cmd;
  sfba_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  sfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfba_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_req_type),
    .in_req_bytes      (in_req_bytes),
    .in_req_address    (in_req_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_grant_address (out_grant_address),
    .out_free_blocks   (out_free_blocks),
    .out_used_blocks   (out_used_blocks),
    .out_used_bytes    (out_used_bytes),
    .out_alloc_calls   (out_alloc_calls),
    .out_free_calls    (out_free_calls),
    .out_split_calls   (out_split_calls),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
